@@ sv/cmlt_pkg.sv @@
// cmlt_pkg: shared types and constants of the color matrix transform
// command codes, queue word layout and fixed-point widths
// no dependencies
package cmlt_pkg;

	typedef enum logic [1:0] {
		OP_PIXEL  = 2'd0,
		OP_GAMMA  = 2'd1,
		OP_OUTPUT = 2'd2,
		OP_MATRIX = 2'd3
	} op_t;

	localparam int NCHAN         = 3;
	localparam int GAMMA_ENTRIES = 256;
	localparam int GAW           = 8;
	localparam int MTX_N         = 9;
	localparam int MAW           = 4;
	localparam int IDXW          = 13;
	localparam int SUM_FRAC      = 29;
	localparam int SUMW          = 35;
	localparam int PRODW         = 33;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	typedef struct packed {
		op_t             op;
		logic [1:0]      chan;
		logic [IDXW-1:0] index;
		logic [15:0]     value;
		logic [7:0]      red;
		logic [7:0]      green;
		logic [7:0]      blue;
		logic [7:0]      alpha;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           full;
	} qstat_t;

endpackage

@@ sv/cmlt_ram.sv @@
// cmlt_ram: generic single write port, single read port RAM
// registered read data, no reset on contents
// no dependencies
module cmlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/cmlt_front.sv @@
// cmlt_front: accepts input words, drops loads that hit nothing, queues the rest
// small register queue toward the execution pipeline
// depends on cmlt_pkg
module cmlt_front #(
	parameter int OUTPUT_TABLE_SIZE = 8192
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [1:0]              command,
	input  logic [1:0]              channel,
	input  logic [12:0]             entry_index,
	input  logic signed [16:0]      entry_value,
	input  logic [7:0]              red_in,
	input  logic [7:0]              green_in,
	input  logic [7:0]              blue_in,
	input  logic [7:0]              alpha_in,
	input  logic                    deq,
	output cmlt_pkg::qhead_t        head,
	output cmlt_pkg::qstat_t        stat
);
	import cmlt_pkg::*;

	logic [QCW-1:0] count_q;
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	item_t          mem_q [QDEPTH];
	item_t          word;
	logic           keep;
	logic           enq;
	logic           chan_ok;
	logic [16:0]    idx_ext;

	assign chan_ok = channel < 2'(NCHAN);
	assign idx_ext = 17'(entry_index);

	always_comb begin
		word.op    = op_t'(command);
		word.chan  = channel;
		word.index = entry_index;
		word.value = entry_value[15:0];
		word.red   = red_in;
		word.green = green_in;
		word.blue  = blue_in;
		word.alpha = alpha_in;
		unique case (op_t'(command))
			OP_PIXEL:  keep = 1'b1;
			OP_GAMMA:  keep = chan_ok && (idx_ext < 17'(GAMMA_ENTRIES));
			OP_OUTPUT: keep = chan_ok && (idx_ext < 17'(OUTPUT_TABLE_SIZE));
			OP_MATRIX: keep = idx_ext < 17'(MTX_N);
			default:   keep = 1'b0;
		endcase
	end

	assign stat.full  = count_q == QCW'(QDEPTH);
	assign stat.count = count_q;
	assign enq        = push && !stat.full && keep;

	assign head.valid = count_q != '0;
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({enq, deq})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/cmlt_back.sv @@
// cmlt_back: five-stage execution pipeline for queued words
// gamma lookup, matrix products, sums and clamp, index scaling, output lookup
// depends on cmlt_pkg and cmlt_ram
module cmlt_back #(
	parameter int OUTPUT_TABLE_SIZE = 8192
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmlt_pkg::qhead_t head,
	output logic             deq,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out,
	output logic [7:0]       alpha_out
);
	import cmlt_pkg::*;

	localparam int OAW = $clog2(OUTPUT_TABLE_SIZE);
	localparam int NW  = $clog2(OUTPUT_TABLE_SIZE + 1);
	localparam int SCW = SUM_FRAC + NW;
	localparam int RNW = SCW + 1;
	localparam int QW  = NW + 1;

	logic        adv;
	logic        res_pend;
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	item_t       it_s1, it_s2, it_s3, it_s4;
	op_t         op_s5;
	logic [7:0]  alpha_s5;

	logic [GAW-1:0]      pix [NCHAN];
	logic [15:0]         g_s1 [NCHAN];
	logic signed [15:0]  coef_q [MTX_N];
	logic signed [PRODW-1:0] prod_s2 [MTX_N];
	logic signed [SUMW-1:0]  sum [NCHAN];
	logic [SUM_FRAC-1:0] lo_s3 [NCHAN];
	logic [NCHAN-1:0]    nonpos_s3, big_s3, nonpos_s4, big_s4;
	logic [SCW-1:0]      scl_s4 [NCHAN];
	logic [RNW-1:0]      rnd [NCHAN];
	logic [QW-1:0]       qidx [NCHAN];
	logic [QW-1:0]       cidx [NCHAN];
	logic [OAW-1:0]      oaddr [NCHAN];
	logic [7:0]          odat [NCHAN];
	logic [16:0]         widx_ext;

	assign res_pend = valid_s5 && (op_s5 == OP_PIXEL);
	assign adv      = !res_pend || pop;
	assign deq      = adv && head.valid;
	assign empty    = !res_pend;

	assign pix[0] = head.item.red;
	assign pix[1] = head.item.green;
	assign pix[2] = head.item.blue;

	// gamma tables, read and written as a word leaves the queue
	for (genvar c = 0; c < NCHAN; c++) begin : g_gamma
		cmlt_ram #(.WIDTH(16), .DEPTH(GAMMA_ENTRIES)) u_gamma (
			.clk   (clk),
			.we    (deq && head.item.op == OP_GAMMA && head.item.chan == 2'(c)),
			.waddr (head.item.index[GAW-1:0]),
			.wdata (head.item.value),
			.re    (adv),
			.raddr (pix[c]),
			.rdata (g_s1[c])
		);
	end

	// matrix coefficients, written at the stage that reads them
	always_ff @(posedge clk) begin
		if (adv && valid_s1 && it_s1.op == OP_MATRIX) begin
			coef_q[it_s1.index[MAW-1:0]] <= it_s1.value;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < MTX_N; k++) begin
				prod_s2[k] <= $signed({1'b0, g_s1[k / NCHAN]}) * coef_q[k];
			end
		end
	end

	always_comb begin
		for (int o = 0; o < NCHAN; o++) begin
			sum[o] = SUMW'(prod_s2[o]) + SUMW'(prod_s2[NCHAN + o])
				+ SUMW'(prod_s2[2 * NCHAN + o]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int o = 0; o < NCHAN; o++) begin
				lo_s3[o]     <= sum[o][SUM_FRAC-1:0];
				nonpos_s3[o] <= sum[o][SUMW-1] || (sum[o] == '0);
				big_s3[o]    <= !sum[o][SUMW-1] && (sum[o][SUMW-2:SUM_FRAC] != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int o = 0; o < NCHAN; o++) begin
				scl_s4[o] <= SCW'(lo_s3[o]) * SCW'(OUTPUT_TABLE_SIZE);
			end
			nonpos_s4 <= nonpos_s3;
			big_s4    <= big_s3;
		end
	end

	// round half up, then clamp to the range from entry zero to the last table entry
	always_comb begin
		for (int o = 0; o < NCHAN; o++) begin
			rnd[o]  = RNW'(scl_s4[o]) + (RNW'(1) << (SUM_FRAC - 1));
			qidx[o] = rnd[o][RNW-1:SUM_FRAC];
			if (nonpos_s4[o]) begin
				cidx[o] = '0;
			end else if (big_s4[o] || qidx[o] > QW'(OUTPUT_TABLE_SIZE - 1)) begin
				cidx[o] = QW'(OUTPUT_TABLE_SIZE - 1);
			end else begin
				cidx[o] = qidx[o];
			end
			oaddr[o] = cidx[o][OAW-1:0];
		end
	end

	assign widx_ext = 17'(it_s4.index);

	for (genvar c = 0; c < NCHAN; c++) begin : g_out
		cmlt_ram #(.WIDTH(8), .DEPTH(OUTPUT_TABLE_SIZE)) u_otab (
			.clk   (clk),
			.we    (adv && valid_s4 && it_s4.op == OP_OUTPUT && it_s4.chan == 2'(c)),
			.waddr (widx_ext[OAW-1:0]),
			.wdata (it_s4.value[7:0]),
			.re    (adv),
			.raddr (oaddr[c]),
			.rdata (odat[c])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1    <= head.item;
			it_s2    <= it_s1;
			it_s3    <= it_s2;
			it_s4    <= it_s3;
			op_s5    <= it_s4.op;
			alpha_s5 <= it_s4.alpha;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= head.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	assign red_out   = odat[0];
	assign green_out = odat[1];
	assign blue_out  = odat[2];
	assign alpha_out = alpha_s5;

endmodule

@@ sv/color_matrix_lut_transform.sv @@
// color_matrix_lut_transform: matrix-shaper color transform, top level
// depends on cmlt_pkg, cmlt_front, cmlt_back, cmlt_ram
//
// Input side is a queue: a word is taken at a rising edge with push high and
// full low. command selects a pixel transform or a load of a gamma entry, an
// output table entry or a matrix coefficient. Loads that name a table or
// entry that does not exist are taken and dropped; loads give no result.
// Result side is a queue too: while empty is low the oldest result is on
// red_out, green_out, blue_out and alpha_out, and it leaves at an edge with
// pop high. One word per cycle is sustained in both directions while pop is
// high whenever empty is low; the gamma read, the nine products, the sums,
// the index scaling and the output table read each take one pipeline stage.
// A pixel is shown after it passes the front queue and every stage in order.
// While a pixel result waits and pop is low the whole pipeline holds; the
// front queue keeps four words, so full rises only once it holds four.
// Reset clears the queue and the pipeline; tables and matrix contents are
// undefined until loaded and must be written before a pixel uses them.
module color_matrix_lut_transform #(
	parameter int OUTPUT_TABLE_SIZE = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         command,
	input  logic [1:0]         channel,
	input  logic [12:0]        entry_index,
	input  logic signed [16:0] entry_value,
	input  logic [7:0]         red_in,
	input  logic [7:0]         green_in,
	input  logic [7:0]         blue_in,
	input  logic [7:0]         alpha_in,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         red_out,
	output logic [7:0]         green_out,
	output logic [7:0]         blue_out,
	output logic [7:0]         alpha_out
);
	import cmlt_pkg::*;

	qhead_t head;
	qstat_t qs;
	logic   deq;

	cmlt_front #(.OUTPUT_TABLE_SIZE(OUTPUT_TABLE_SIZE)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.command     (command),
		.channel     (channel),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.alpha_in    (alpha_in),
		.deq         (deq),
		.head        (head),
		.stat        (qs)
	);

	cmlt_back #(.OUTPUT_TABLE_SIZE(OUTPUT_TABLE_SIZE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.deq       (deq),
		.pop       (pop),
		.empty     (empty),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out)
	);

	assign full = qs.full;

	a_qcount: assert property (@(posedge clk) disable iff (!arst_n)
		qs.count <= QCW'(QDEPTH))
		else $error("queue count beyond depth");

	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> qs.count != '0)
		else $error("dequeue from empty queue");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |-> !deq)
		else $error("pipeline advanced while result stalled");

endmodule
